@@ hdl/pbq_pkg.sv @@
`default_nettype none

package pbq_pkg;

   localparam int LEN_W   = 16;
   localparam int PAY_W   = 48;
   localparam int ENTRY_W = LEN_W + PAY_W;
   localparam int HW_W    = 20;
   localparam int BYTES_W = 21;
   localparam int OP_W    = 2;
   localparam int OPC_W   = 3;

   // Command fields wide enough for the largest supported queue depth (63)
   localparam int QPTR_W = 6;
   localparam int QCNT_W = 6;

   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [HW_W-1:0] HW_RESET = 20'd4096;

   localparam logic PORT_DEVICE = 1'b0;
   localparam logic PORT_HUB    = 1'b1;

   localparam logic [OP_W-1:0] OP_POLL      = 2'd0;
   localparam logic [OP_W-1:0] OP_DATA      = 2'd1;
   localparam logic [OP_W-1:0] OP_HUB_GRANT = 2'd2;

   localparam logic [OPC_W-1:0] OPC_READY    = 3'd0;
   localparam logic [OPC_W-1:0] OPC_REQ_SLOT = 3'd1;
   localparam logic [OPC_W-1:0] OPC_PAUSE    = 3'd2;
   localparam logic [OPC_W-1:0] OPC_DONE     = 3'd3;
   localparam logic [OPC_W-1:0] OPC_RESUME   = 3'd4;
   localparam logic [OPC_W-1:0] OPC_DATA     = 3'd5;

   // Result groups of one command, highest bit goes out first
   localparam int EMIT_W   = 7;
   localparam int E_READY  = 6;
   localparam int E_REQ    = 5;
   localparam int E_PAUSE  = 4;
   localparam int E_DRAIN  = 3;
   localparam int E_DONE   = 2;
   localparam int E_RESUME = 1;
   localparam int E_FWD    = 0;

   typedef struct packed {
      logic [EMIT_W-1:0] emit;
      logic [QCNT_W-1:0] drain_count;
      logic [QPTR_W-1:0] drain_start;
      logic [LEN_W-1:0]  fwd_length;
      logic [PAY_W-1:0]  fwd_payload;
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/pbq_ram.sv @@
`default_nettype none

module pbq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/pbq_front.sv @@
`default_nettype none

module pbq_front #(
   parameter int QUEUE_DEPTH = 16,
   localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_source_port,
   input  logic [pbq_pkg::OP_W-1:0]    req_operation,
   input  logic [pbq_pkg::LEN_W-1:0]   req_packet_length,
   input  logic [pbq_pkg::PAY_W-1:0]   req_packet_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pbq_pkg::HW_W-1:0]    csr_high_water_bytes,
   input  logic                        fifo_full,
   output logic                        push_valid,
   output pbq_pkg::cmd_type            push_cmd,
   input  logic                        drain_done,
   output logic                        ram_wr_en,
   output logic [PTR_W-1:0]            ram_wr_addr,
   output logic [pbq_pkg::ENTRY_W-1:0] ram_wr_data
);

   import pbq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic              active_ff, active_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic              paused_ff, paused_in;
   logic              slot_ff, slot_in;
   logic              drain_wait_ff, drain_wait_in;
   logic [HW_W-1:0]   hw_ff, hw_in;

   logic               accept;
   logic               q_full;
   logic [BYTES_W:0]   bytes_sum;
   logic [BYTES_W-1:0] bytes_new;
   logic [CNT_W-1:0]   count_new;
   logic               want_slot;
   logic               want_pause;
   cmd_type            cmd;

   assign csr_ready = 1'b1;
   assign req_stall = fifo_full | drain_wait_ff;
   assign accept    = req_valid & ~req_stall;

   assign q_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(req_packet_length);
   assign bytes_new = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
   assign count_new = count_ff + 1'b1;
   assign want_slot = (count_ff == '0) & ~slot_ff;
   assign want_pause = ~paused_ff &
                       ((bytes_new >= {1'b0, hw_ff}) || (count_new >= CNT_W'(QUEUE_DEPTH - 2)));

   always_comb begin
      active_in     = active_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      bytes_in      = bytes_ff;
      paused_in     = paused_ff;
      slot_in       = slot_ff;
      drain_wait_in = drain_wait_ff & ~drain_done;
      hw_in         = (csr_valid & csr_ready) ? csr_high_water_bytes : hw_ff;
      cmd           = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wp_ff;
      ram_wr_data   = {req_packet_length, req_packet_payload};

      if (accept) begin
         if (req_source_port == PORT_DEVICE) begin
            unique case (req_operation)
               OP_POLL: begin
                  cmd.emit[E_READY] = 1'b1;
                  active_in         = 1'b1;
                  if (active_ff) begin
                     // flush the queue
                     rp_in     = '0;
                     wp_in     = '0;
                     count_in  = '0;
                     bytes_in  = '0;
                     paused_in = 1'b0;
                     slot_in   = 1'b0;
                  end
               end
               OP_DATA: begin
                  active_in = 1'b1;
                  if (!q_full) begin
                     ram_wr_en         = 1'b1;
                     wp_in             = (wp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                     count_in          = count_new;
                     bytes_in          = bytes_new;
                     cmd.emit[E_REQ]   = want_slot;
                     cmd.emit[E_PAUSE] = want_pause;
                     slot_in           = slot_ff | want_slot;
                     paused_in         = paused_ff | want_pause;
                  end
               end
               default: begin
               end
            endcase
         end else if (active_ff) begin
            unique case (req_operation)
               OP_HUB_GRANT: begin
                  cmd.emit[E_DRAIN]  = (count_ff != '0);
                  cmd.emit[E_DONE]   = 1'b1;
                  cmd.emit[E_RESUME] = paused_ff;
                  cmd.drain_count    = QCNT_W'(count_ff);
                  cmd.drain_start    = QPTR_W'(rp_ff);
                  rp_in              = wp_ff;
                  count_in           = '0;
                  bytes_in           = '0;
                  paused_in          = 1'b0;
                  slot_in            = 1'b0;
                  drain_wait_in      = (count_ff != '0);
               end
               OP_DATA: begin
                  cmd.emit[E_FWD] = 1'b1;
                  cmd.fwd_length  = req_packet_length;
                  cmd.fwd_payload = req_packet_payload;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign push_valid = accept & (|cmd.emit);
   assign push_cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rp_ff         <= '0;
         wp_ff         <= '0;
         count_ff      <= '0;
         bytes_ff      <= '0;
         paused_ff     <= 1'b0;
         slot_ff       <= 1'b0;
         drain_wait_ff <= 1'b0;
         hw_ff         <= HW_RESET;
      end else begin
         active_ff     <= active_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         bytes_ff      <= bytes_in;
         paused_ff     <= paused_in;
         slot_ff       <= slot_in;
         drain_wait_ff <= drain_wait_in;
         hw_ff         <= hw_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/pbq_cmd_fifo.sv @@
`default_nettype none

module pbq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  pbq_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output pbq_pkg::cmd_type head
);

   import pbq_pkg::*;

   localparam int IDX_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type          entries_ff [CMD_FIFO_DEPTH];
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(CMD_FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_idx_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (do_pop) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_idx_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/pbq_back.sv @@
`default_nettype none

module pbq_back #(
   parameter int QUEUE_DEPTH = 16,
   localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_not_empty,
   input  pbq_pkg::cmd_type            cmd_head,
   output logic                        cmd_pop,
   output logic                        drain_done,
   output logic [PTR_W-1:0]            ram_rd_addr,
   input  logic [pbq_pkg::ENTRY_W-1:0] ram_rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_destination_port,
   output logic [pbq_pkg::OPC_W-1:0]   rsp_out_opcode,
   output logic [pbq_pkg::LEN_W-1:0]   rsp_out_length,
   output logic [pbq_pkg::PAY_W-1:0]   rsp_out_payload,
   output logic                        rsp_last_result
);

   import pbq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic              busy_ff, busy_in;
   logic [EMIT_W-1:0] emit_ff, emit_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [LEN_W-1:0]  fwd_len_ff, fwd_len_in;
   logic [PAY_W-1:0]  fwd_pay_ff, fwd_pay_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_dest_ff, out_dest_in;
   logic [OPC_W-1:0]  out_opc_ff, out_opc_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [PAY_W-1:0]  out_pay_ff, out_pay_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic [EMIT_W-1:0] emit_next;
   logic              sel_dest;
   logic [OPC_W-1:0]  sel_opc;
   logic [LEN_W-1:0]  sel_len;
   logic [PAY_W-1:0]  sel_pay;
   logic              sel_drain;
   logic              finishing;

   assign advance = busy_ff & (~out_valid_ff | ~rsp_stall);

   // pick the next result of the current command in output order
   always_comb begin
      emit_next = emit_ff;
      sel_dest  = PORT_DEVICE;
      sel_opc   = OPC_READY;
      sel_len   = '0;
      sel_pay   = '0;
      sel_drain = 1'b0;
      priority if (emit_ff[E_READY]) begin
         emit_next[E_READY] = 1'b0;
      end else if (emit_ff[E_REQ]) begin
         emit_next[E_REQ] = 1'b0;
         sel_dest         = PORT_HUB;
         sel_opc          = OPC_REQ_SLOT;
      end else if (emit_ff[E_PAUSE]) begin
         emit_next[E_PAUSE] = 1'b0;
         sel_opc            = OPC_PAUSE;
      end else if (emit_ff[E_DRAIN]) begin
         emit_next[E_DRAIN] = (cnt_ff != CNT_W'(1));
         sel_dest           = PORT_HUB;
         sel_opc            = OPC_DATA;
         sel_len            = ram_rd_data[ENTRY_W-1:PAY_W];
         sel_pay            = ram_rd_data[PAY_W-1:0];
         sel_drain          = 1'b1;
      end else if (emit_ff[E_DONE]) begin
         emit_next[E_DONE] = 1'b0;
         sel_dest          = PORT_HUB;
         sel_opc           = OPC_DONE;
      end else if (emit_ff[E_RESUME]) begin
         emit_next[E_RESUME] = 1'b0;
         sel_opc             = OPC_RESUME;
      end else begin
         emit_next[E_FWD] = 1'b0;
         sel_opc          = OPC_DATA;
         sel_len          = fwd_len_ff;
         sel_pay          = fwd_pay_ff;
      end
   end

   assign finishing  = advance & (emit_next == '0);
   assign cmd_pop    = cmd_not_empty & (~busy_ff | finishing);
   assign drain_done = advance & sel_drain & (cnt_ff == CNT_W'(1));

   always_comb begin
      busy_in    = busy_ff;
      emit_in    = emit_ff;
      cnt_in     = cnt_ff;
      rp_in      = rp_ff;
      fwd_len_in = fwd_len_ff;
      fwd_pay_in = fwd_pay_ff;
      if (advance) begin
         emit_in = emit_next;
         if (sel_drain) begin
            cnt_in = cnt_ff - 1'b1;
            rp_in  = (rp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
      if (cmd_pop) begin
         busy_in    = 1'b1;
         emit_in    = cmd_head.emit;
         cnt_in     = cmd_head.drain_count[CNT_W-1:0];
         rp_in      = cmd_head.drain_start[PTR_W-1:0];
         fwd_len_in = cmd_head.fwd_length;
         fwd_pay_in = cmd_head.fwd_payload;
      end
   end

   // read ahead so the entry at the read pointer is ready in the next cycle
   assign ram_rd_addr = rp_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_dest_in  = out_dest_ff;
      out_opc_in   = out_opc_ff;
      out_len_in   = out_len_ff;
      out_pay_in   = out_pay_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_dest_in  = sel_dest;
         out_opc_in   = sel_opc;
         out_len_in   = sel_len;
         out_pay_in   = sel_pay;
         out_last_in  = (emit_next == '0);
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff     <= emit_in;
      cnt_ff      <= cnt_in;
      rp_ff       <= rp_in;
      fwd_len_ff  <= fwd_len_in;
      fwd_pay_ff  <= fwd_pay_in;
      out_dest_ff <= out_dest_in;
      out_opc_ff  <= out_opc_in;
      out_len_ff  <= out_len_in;
      out_pay_ff  <= out_pay_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_destination_port = out_dest_ff;
   assign rsp_out_opcode       = out_opc_ff;
   assign rsp_out_length       = out_len_ff;
   assign rsp_out_payload      = out_pay_ff;
   assign rsp_last_result      = out_last_ff;

endmodule

`default_nettype wire

@@ hdl/packet_bridge_queue_with_backpressure.sv @@
`default_nettype none

// Channel  Direction  Handshake            Transaction contents
// req_     in         req_valid/req_stall  source port, operation, length, payload
// rsp_     out        rsp_valid/rsp_stall  destination port, opcode, length, payload, last flag
// csr_     in         csr_valid/csr_ready  high-water byte mark (20 bits), always ready
//
// Input transactions are taken one per cycle while the command queue has room and no drain is pending.
// Results leave one per cycle while rsp_stall is low, via command queue and output register.
// A grant with queued packets holds req_stall high until its last DATA is loaded into the
// output register; input is taken again from the next cycle on.
// Synchronous active-high reset; no clearing pass, queue entries are only read once written.

module packet_bridge_queue_with_backpressure #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_source_port,
   input  logic [pbq_pkg::OP_W-1:0]  req_operation,
   input  logic [pbq_pkg::LEN_W-1:0] req_packet_length,
   input  logic [pbq_pkg::PAY_W-1:0] req_packet_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_destination_port,
   output logic [pbq_pkg::OPC_W-1:0] rsp_out_opcode,
   output logic [pbq_pkg::LEN_W-1:0] rsp_out_length,
   output logic [pbq_pkg::PAY_W-1:0] rsp_out_payload,
   output logic                      rsp_last_result,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pbq_pkg::HW_W-1:0]  csr_high_water_bytes
);

   import pbq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   // front to queue
   logic              push_valid;
   cmd_type           push_cmd;
   logic              fifo_full;
   // queue to back
   logic              cmd_not_empty;
   cmd_type           cmd_head;
   logic              cmd_pop;
   // back tells front the drain is over, so the packet memory may be written again
   logic              drain_done;
   // packet memory
   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // classify packets, keep link/queue bookkeeping, write the packet memory
   pbq_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_source_port      (req_source_port),
      .req_operation        (req_operation),
      .req_packet_length    (req_packet_length),
      .req_packet_payload   (req_packet_payload),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_high_water_bytes (csr_high_water_bytes),
      .fifo_full            (fifo_full),
      .push_valid           (push_valid),
      .push_cmd             (push_cmd),
      .drain_done           (drain_done),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data)
   );

   // hold commands between the two halves so each can stall on its own
   pbq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (cmd_pop),
      .not_empty  (cmd_not_empty),
      .head       (cmd_head)
   );

   // queued packet lengths and payloads
   pbq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_packet_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // expand each command into its results, drain the memory on a grant
   pbq_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_not_empty        (cmd_not_empty),
      .cmd_head             (cmd_head),
      .cmd_pop              (cmd_pop),
      .drain_done           (drain_done),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_destination_port (rsp_destination_port),
      .rsp_out_opcode       (rsp_out_opcode),
      .rsp_out_length       (rsp_out_length),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_last_result      (rsp_last_result)
   );

endmodule

`default_nettype wire
